FILE: rtl/core/bilut_pkg.sv
// Shared constants, types and helpers for the bilinear undistortion table lookup.
// Depends on nothing; every other file of the block but bilut_ram imports it.
package bilut_pkg;

	localparam int MAX_WIDTH       = 640;
	localparam int MAX_HEIGHT      = 480;
	localparam int COORD_FRAC_BITS = 8;
	localparam int VALUE_FRAC_BITS = 14;

	localparam int POS_W   = 19;
	localparam int VAL_W   = 18;
	localparam int WIDTH_W = 10;
	localparam int HEIGHT_W = 9;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 10;

	// integer pixel position after flooring a non-negative coordinate
	localparam int CR_W  = POS_W - COORD_FRAC_BITS - 1;
	localparam int CMP_W = CR_W + 1;

	localparam int TAB_DEPTH  = MAX_WIDTH * MAX_HEIGHT;
	localparam int IDX_W      = $clog2(TAB_DEPTH);
	localparam int BANK_DEPTH = (TAB_DEPTH + 1) / 2;
	localparam int BANK_AW    = IDX_W - 1;
	localparam int ENTRY_W    = 2 * VAL_W;

	localparam int WGT_W  = 2 * COORD_FRAC_BITS + 1;
	localparam int PRD_W  = VAL_W + WGT_W + 1;
	localparam int ACC_W  = PRD_W + 2;
	localparam int BLEND_SHIFT = 2 * COORD_FRAC_BITS;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

	localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = WIDTH_W'(640);
	localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = HEIGHT_W'(480);

	localparam logic FUNC_WRITE = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

	typedef logic signed [POS_W-1:0]  pos_t;
	typedef logic signed [VAL_W-1:0]  val_t;
	typedef logic [WIDTH_W-1:0]       width_t;
	typedef logic [HEIGHT_W-1:0]      height_t;
	typedef logic [CR_W-1:0]          coord_t;
	typedef logic [COORD_FRAC_BITS-1:0] frac_t;
	typedef logic [COORD_FRAC_BITS:0]   wside_t;
	typedef logic [WGT_W-1:0]         wgt_t;
	typedef logic [IDX_W-1:0]         idx_t;
	typedef logic [BANK_AW-1:0]       bank_addr_t;
	typedef logic signed [PRD_W-1:0]  prd_t;
	typedef logic signed [ACC_W-1:0]  acc_t;

	typedef struct packed {
		val_t x;
		val_t y;
	} entry_t;

	typedef struct packed {
		logic       we;
		logic       re;
		bank_addr_t waddr;
		entry_t     wdata;
		bank_addr_t raddr_a;
		bank_addr_t raddr_b;
	} ram_req_t;

	typedef struct packed {
		entry_t even_a;
		entry_t even_b;
		entry_t odd_a;
		entry_t odd_b;
	} bank_rd_t;

	// query leaving the address stage toward the blend pipeline
	typedef struct packed {
		logic valid;
		logic in_range;
		logic par_a;
		logic par_b;
		wgt_t w00;
		wgt_t w10;
		wgt_t w01;
		wgt_t w11;
	} lkp_ctl_t;

	localparam acc_t ACC_HALF = acc_t'(64'd1 << (BLEND_SHIFT - 1));

	function automatic wgt_t wgt_mul(wside_t a, wside_t b);
		logic [2*COORD_FRAC_BITS+1:0] p;
		p = {{(COORD_FRAC_BITS+1){1'b0}}, a} * {{(COORD_FRAC_BITS+1){1'b0}}, b};
		return p[WGT_W-1:0];
	endfunction

	function automatic prd_t val_mul(val_t q, wgt_t w);
		prd_t a;
		prd_t b;
		a = prd_t'(q);
		b = prd_t'($signed({1'b0, w}));
		return a * b;
	endfunction

	// floor shift of the rounded sum, then clamp to the value range
	function automatic val_t round_sat(acc_t t);
		acc_t sh;
		logic [ACC_W-VAL_W:0] top;
		sh = (t + ACC_HALF) >>> BLEND_SHIFT;
		top = sh[ACC_W-1:VAL_W-1];
		if ((&top) || !(|top))
			return sh[VAL_W-1:0];
		else if (sh[ACC_W-1])
			return {1'b1, {(VAL_W-1){1'b0}}};
		else
			return {1'b0, {(VAL_W-1){1'b1}}};
	endfunction

endpackage

FILE: rtl/core/bilut_ifs.sv
// Handshake channels of the table lookup: request, response and configuration write.
// Depends on bilut_pkg for payload types.
interface bilut_req_if;
	import bilut_pkg::*;
	logic valid;
	logic ready;
	logic func;
	pos_t x_pos;
	pos_t y_pos;
	val_t entry_x;
	val_t entry_y;
	modport source(output valid, func, x_pos, y_pos, entry_x, entry_y, input ready);
	modport sink(input valid, func, x_pos, y_pos, entry_x, entry_y, output ready);
endinterface

interface bilut_rsp_if;
	import bilut_pkg::*;
	logic valid;
	logic ready;
	val_t norm_x;
	val_t norm_y;
	logic in_range;
	modport source(output valid, norm_x, norm_y, in_range, input ready);
	modport sink(input valid, norm_x, norm_y, in_range, output ready);
endinterface

interface bilut_cfg_if;
	import bilut_pkg::*;
	logic valid;
	logic ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

FILE: rtl/core/bilut_ram.sv
// Generic synchronous RAM: one write port, two read ports, registered read data.
// Stand-alone; read registers hold while read enable is low.
module bilut_ram #(
	parameter int WIDTH = 36,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end
endmodule

FILE: rtl/core/bilut_cfg.sv
// Configuration registers for image width and height, clamped to the table size.
// Depends on bilut_pkg and the configuration channel in bilut_ifs.
module bilut_cfg (
	input  logic                  clk,
	input  logic                  arst_n,
	bilut_cfg_if.sink             cfg,
	output bilut_pkg::width_t     eff_w,
	output bilut_pkg::height_t    eff_h
);
	import bilut_pkg::*;

	width_t  width_q;
	height_t height_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_IMAGE_WIDTH:  width_q  <= cfg.data[WIDTH_W-1:0];
				REG_IMAGE_HEIGHT: height_q <= cfg.data[HEIGHT_W-1:0];
				default: ;
			endcase
		end
	end

	// an oversized register acts as the table maximum
	assign eff_w = (32'(width_q) > MAX_WIDTH) ? WIDTH_W'(MAX_WIDTH) : width_q;
	assign eff_h = (32'(height_q) > MAX_HEIGHT) ? HEIGHT_W'(MAX_HEIGHT) : height_q;
endmodule

FILE: rtl/core/bilut_addr.sv
// Address stage: floors positions, checks range, forms the four neighbor indexes,
// drives both table banks and computes the blend weights. Depends on bilut_pkg.
module bilut_addr (
	input  logic                  clk,
	input  logic                  arst_n,
	bilut_req_if.sink             req,
	input  bilut_pkg::width_t     eff_w,
	input  bilut_pkg::height_t    eff_h,
	input  logic                  adv,
	output bilut_pkg::lkp_ctl_t   ctl,
	output bilut_pkg::ram_req_t   even_req,
	output bilut_pkg::ram_req_t   odd_req
);
	import bilut_pkg::*;

	logic   neg;
	coord_t col;
	coord_t row;
	logic   wr_ok;
	logic   qr_ok;
	idx_t   prod;

	logic    v_s1;
	logic    func_s1;
	logic    wr_ok_s1;
	logic    qr_ok_s1;
	idx_t    prod_s1;
	coord_t  row_s1;
	height_t h_s1;
	frac_t   dx_s1;
	frac_t   dy_s1;
	entry_t  ent_s1;

	logic   leave;
	logic   wr;
	idx_t   i00;
	idx_t   i01;
	idx_t   i10;
	idx_t   i11;
	wside_t dxe;
	wside_t dye;
	wside_t sdx;
	wside_t sdy;

	// input side: floor, range check and column product
	assign neg = req.x_pos[POS_W-1] | req.y_pos[POS_W-1];
	assign col = req.x_pos[POS_W-2:COORD_FRAC_BITS];
	assign row = req.y_pos[POS_W-2:COORD_FRAC_BITS];

	assign wr_ok = !neg && (CMP_W'(col) < CMP_W'(eff_w)) && (CMP_W'(row) < CMP_W'(eff_h));
	assign qr_ok = !neg && (CMP_W'(col) + CMP_W'(1) < CMP_W'(eff_w))
		&& (CMP_W'(row) + CMP_W'(1) < CMP_W'(eff_h));
	assign prod = IDX_W'(eff_h) * IDX_W'(col);

	// a write leaves at once; a query waits for the blend pipeline
	assign leave = (func_s1 == FUNC_WRITE) || adv;
	assign req.ready = !v_s1 || leave;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (req.ready)
			v_s1 <= req.valid;
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			func_s1  <= req.func;
			wr_ok_s1 <= wr_ok;
			qr_ok_s1 <= qr_ok;
			prod_s1  <= prod;
			row_s1   <= row;
			h_s1     <= eff_h;
			dx_s1    <= req.x_pos[COORD_FRAC_BITS-1:0];
			dy_s1    <= req.y_pos[COORD_FRAC_BITS-1:0];
			ent_s1   <= '{x: req.entry_x, y: req.entry_y};
		end
	end

	// neighbor indexes; i00/i01 and i10/i11 always fall into opposite banks
	assign i00 = prod_s1 + IDX_W'(row_s1);
	assign i01 = i00 + IDX_W'(1);
	assign i10 = i00 + IDX_W'(h_s1);
	assign i11 = i10 + IDX_W'(1);

	assign wr = v_s1 && (func_s1 == FUNC_WRITE) && wr_ok_s1;

	always_comb begin
		even_req.we      = wr && !i00[0];
		even_req.re      = adv;
		even_req.waddr   = i00[IDX_W-1:1];
		even_req.wdata   = ent_s1;
		even_req.raddr_a = qr_ok_s1 ? i01[IDX_W-1:1] : '0;
		even_req.raddr_b = qr_ok_s1 ? i11[IDX_W-1:1] : '0;

		odd_req.we       = wr && i00[0];
		odd_req.re       = adv;
		odd_req.waddr    = i00[IDX_W-1:1];
		odd_req.wdata    = ent_s1;
		odd_req.raddr_a  = qr_ok_s1 ? i00[IDX_W-1:1] : '0;
		odd_req.raddr_b  = qr_ok_s1 ? i10[IDX_W-1:1] : '0;
	end

	assign dxe = {1'b0, dx_s1};
	assign dye = {1'b0, dy_s1};
	assign sdx = {1'b1, {COORD_FRAC_BITS{1'b0}}} - dxe;
	assign sdy = {1'b1, {COORD_FRAC_BITS{1'b0}}} - dye;

	always_comb begin
		ctl.valid    = v_s1 && (func_s1 == FUNC_QUERY);
		ctl.in_range = qr_ok_s1;
		ctl.par_a    = i00[0];
		ctl.par_b    = i10[0];
		ctl.w00      = wgt_mul(sdx, sdy);
		ctl.w10      = wgt_mul(dxe, sdy);
		ctl.w01      = wgt_mul(sdx, dye);
		ctl.w11      = wgt_mul(dxe, dye);
	end
endmodule

FILE: rtl/core/bilut_blend.sv
// Blend pipeline: routes bank data to neighbor slots, weights, sums, rounds and
// saturates, then holds the result in the output register. Depends on bilut_pkg.
module bilut_blend (
	input  logic                  clk,
	input  logic                  arst_n,
	input  bilut_pkg::lkp_ctl_t   ctl,
	input  bilut_pkg::bank_rd_t   rd,
	output logic                  adv,
	bilut_rsp_if.source           rsp
);
	import bilut_pkg::*;

	logic en_o;
	logic en4;
	logic en3;

	logic v_s2;
	logic rng_s2;
	logic pa_s2;
	logic pb_s2;
	wgt_t w00_s2;
	wgt_t w10_s2;
	wgt_t w01_s2;
	wgt_t w11_s2;

	entry_t q00;
	entry_t q01;
	entry_t q10;
	entry_t q11;

	logic v_s3;
	logic rng_s3;
	prd_t px_s3 [4];
	prd_t py_s3 [4];

	logic v_s4;
	logic rng_s4;
	acc_t xa_s4;
	acc_t xb_s4;
	acc_t ya_s4;
	acc_t yb_s4;

	logic valid_q;
	val_t norm_x_q;
	val_t norm_y_q;
	logic in_range_q;

	// each stage advances into an empty or advancing successor
	assign en_o = !valid_q || rsp.ready;
	assign en4  = !v_s4 || en_o;
	assign en3  = !v_s3 || en4;
	assign adv  = !v_s2 || en3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_s4    <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			if (adv)
				v_s2 <= ctl.valid;
			if (en3)
				v_s3 <= v_s2;
			if (en4)
				v_s4 <= v_s3;
			if (en_o)
				valid_q <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rng_s2 <= ctl.in_range;
			pa_s2  <= ctl.par_a;
			pb_s2  <= ctl.par_b;
			w00_s2 <= ctl.w00;
			w10_s2 <= ctl.w10;
			w01_s2 <= ctl.w01;
			w11_s2 <= ctl.w11;
		end
	end

	// bank parity of the base index decides which port holds which neighbor
	assign q00 = pa_s2 ? rd.odd_a  : rd.even_a;
	assign q01 = pa_s2 ? rd.even_a : rd.odd_a;
	assign q10 = pb_s2 ? rd.odd_b  : rd.even_b;
	assign q11 = pb_s2 ? rd.even_b : rd.odd_b;

	always_ff @(posedge clk) begin
		if (en3) begin
			rng_s3   <= rng_s2;
			px_s3[0] <= val_mul(q00.x, w00_s2);
			px_s3[1] <= val_mul(q10.x, w10_s2);
			px_s3[2] <= val_mul(q01.x, w01_s2);
			px_s3[3] <= val_mul(q11.x, w11_s2);
			py_s3[0] <= val_mul(q00.y, w00_s2);
			py_s3[1] <= val_mul(q10.y, w10_s2);
			py_s3[2] <= val_mul(q01.y, w01_s2);
			py_s3[3] <= val_mul(q11.y, w11_s2);
		end
	end

	always_ff @(posedge clk) begin
		if (en4) begin
			rng_s4 <= rng_s3;
			xa_s4  <= acc_t'(px_s3[0]) + acc_t'(px_s3[1]);
			xb_s4  <= acc_t'(px_s3[2]) + acc_t'(px_s3[3]);
			ya_s4  <= acc_t'(py_s3[0]) + acc_t'(py_s3[1]);
			yb_s4  <= acc_t'(py_s3[2]) + acc_t'(py_s3[3]);
		end
	end

	always_ff @(posedge clk) begin
		if (en_o) begin
			in_range_q <= rng_s4;
			norm_x_q   <= rng_s4 ? round_sat(xa_s4 + xb_s4) : '0;
			norm_y_q   <= rng_s4 ? round_sat(ya_s4 + yb_s4) : '0;
		end
	end

	assign rsp.valid    = valid_q;
	assign rsp.norm_x   = norm_x_q;
	assign rsp.norm_y   = norm_y_q;
	assign rsp.in_range = in_range_q;
endmodule

FILE: rtl/core/bilinear_undistort_table_lookup.sv
// Top level of the bilinear undistortion table lookup: config, address stage,
// two table banks split by index parity, and the blend pipeline. Depends on all rtl/core files.
//
//   channel  dir  payload                                   completes when
//   req      in   func, x_pos, y_pos, entry_x, entry_y      req.valid & req.ready
//   rsp      out  norm_x, norm_y, in_range (queries only)   rsp.valid & rsp.ready
//   cfg      in   index, data                               cfg.valid & cfg.ready
//
// One transaction per clock while req.ready is high. A query's result passes the address,
// bank-read, product and sum registers into rsp; writes produce no result and are committed
// from the address register. The two dual-read banks give all four neighbors together and set no limit.
// Reset clears control and loads 640 x 480; table contents are undefined until written.
// Stalls on rsp fill the pipeline bubbles first; req.ready drops only when all stages hold data.
module bilinear_undistort_table_lookup (
	input  logic        clk,
	input  logic        arst_n,
	bilut_req_if.sink   req,
	bilut_rsp_if.source rsp,
	bilut_cfg_if.sink   cfg
);
	import bilut_pkg::*;

	width_t   eff_w;
	height_t  eff_h;
	logic     adv;
	lkp_ctl_t ctl;
	ram_req_t even_req;
	ram_req_t odd_req;
	bank_rd_t rd;
	logic [ENTRY_W-1:0] even_a;
	logic [ENTRY_W-1:0] even_b;
	logic [ENTRY_W-1:0] odd_a;
	logic [ENTRY_W-1:0] odd_b;

	bilut_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.eff_w  (eff_w),
		.eff_h  (eff_h)
	);

	bilut_addr u_addr (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.eff_w    (eff_w),
		.eff_h    (eff_h),
		.adv      (adv),
		.ctl      (ctl),
		.even_req (even_req),
		.odd_req  (odd_req)
	);

	bilut_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (BANK_DEPTH)
	) u_even (
		.clk     (clk),
		.we      (even_req.we),
		.waddr   (even_req.waddr),
		.wdata   (even_req.wdata),
		.re      (even_req.re),
		.raddr_a (even_req.raddr_a),
		.raddr_b (even_req.raddr_b),
		.rdata_a (even_a),
		.rdata_b (even_b)
	);

	bilut_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (BANK_DEPTH)
	) u_odd (
		.clk     (clk),
		.we      (odd_req.we),
		.waddr   (odd_req.waddr),
		.wdata   (odd_req.wdata),
		.re      (odd_req.re),
		.raddr_a (odd_req.raddr_a),
		.raddr_b (odd_req.raddr_b),
		.rdata_a (odd_a),
		.rdata_b (odd_b)
	);

	assign rd.even_a = entry_t'(even_a);
	assign rd.even_b = entry_t'(even_b);
	assign rd.odd_a  = entry_t'(odd_a);
	assign rd.odd_b  = entry_t'(odd_b);

	bilut_blend u_blend (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.rd     (rd),
		.adv    (adv),
		.rsp    (rsp)
	);
endmodule
